### rtl/core/mrsd_pkg.sv
// shared types, constants and sequence helpers for the multicast dedup scoreboard
`default_nettype none

package mrsd_pkg;

   localparam int unsigned SEQ_W = 12;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FEATURE_SWITCH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PACK_ENABLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STATION_MODE   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_JUDGE,
      ST_SLIDE,
      ST_SLIDE_CHK,
      ST_FORCE,
      ST_FL_RD,
      ST_FL_CHK,
      ST_FL_WIN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_ACCEPT,
      CMD_JUDGE,
      CMD_SLIDE_STEP,
      CMD_SLIDE_MARK,
      CMD_FORCE,
      CMD_FL_READ,
      CMD_FL_STEP,
      CMD_FL_WIN,
      CMD_FL_END,
      CMD_LOAD_OUT
   } cmd_type;

   typedef struct packed {
      cmd_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic tracked;
      logic dup;
      logic br_a;
      logic br_b;
      logic br_c;
      logic force_b;
      logic force_c;
      logic fl_adv;
      logic fl_win_more;
      logic out_free;
   } dp_status_type;

   // a at or after b
   function automatic logic seq_geq(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return ~d[SEQ_W-1];
   endfunction

   // a strictly before b
   function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = b - a;
      return (d != '0) && ~d[SEQ_W-1];
   endfunction

endpackage

`default_nettype wire

### rtl/core/mrsd_ctrl.sv
// controller state machine for the multicast dedup scoreboard
`default_nettype none

module mrsd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire mrsd_pkg::dp_status_type stat,
   output mrsd_pkg::dp_cmd_type    cmd
);

   mrsd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrsd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrsd_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = mrsd_pkg::ST_IDLE;
         end
         mrsd_pkg::ST_IDLE: begin
            if (req_valid) state_in = stat.tracked ? mrsd_pkg::ST_JUDGE : mrsd_pkg::ST_DONE;
         end
         mrsd_pkg::ST_JUDGE: begin
            if (stat.dup) state_in = mrsd_pkg::ST_DONE;
            else if (stat.br_a) state_in = mrsd_pkg::ST_FL_RD;
            else if (stat.br_b) state_in = stat.force_b ? mrsd_pkg::ST_FORCE : mrsd_pkg::ST_DONE;
            else if (stat.br_c) state_in = mrsd_pkg::ST_SLIDE;
            else state_in = mrsd_pkg::ST_DONE;
         end
         mrsd_pkg::ST_SLIDE: begin
            if (!stat.br_c) state_in = mrsd_pkg::ST_SLIDE_CHK;
         end
         mrsd_pkg::ST_SLIDE_CHK: begin
            state_in = stat.force_c ? mrsd_pkg::ST_FORCE : mrsd_pkg::ST_FL_RD;
         end
         mrsd_pkg::ST_FORCE:  state_in = mrsd_pkg::ST_FL_RD;
         mrsd_pkg::ST_FL_RD:  state_in = mrsd_pkg::ST_FL_CHK;
         mrsd_pkg::ST_FL_CHK: begin
            state_in = stat.fl_adv ? mrsd_pkg::ST_FL_RD : mrsd_pkg::ST_FL_WIN;
         end
         mrsd_pkg::ST_FL_WIN: begin
            if (!stat.fl_win_more) state_in = mrsd_pkg::ST_DONE;
         end
         mrsd_pkg::ST_DONE: begin
            if (stat.out_free) state_in = mrsd_pkg::ST_IDLE;
         end
         default: state_in = mrsd_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = mrsd_pkg::CMD_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         mrsd_pkg::ST_CLEAR: cmd.op = mrsd_pkg::CMD_CLEAR;
         mrsd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = mrsd_pkg::CMD_ACCEPT;
         end
         mrsd_pkg::ST_JUDGE: cmd.op = mrsd_pkg::CMD_JUDGE;
         mrsd_pkg::ST_SLIDE: begin
            cmd.op = stat.br_c ? mrsd_pkg::CMD_SLIDE_STEP : mrsd_pkg::CMD_SLIDE_MARK;
         end
         mrsd_pkg::ST_SLIDE_CHK: cmd.op = mrsd_pkg::CMD_NONE;
         mrsd_pkg::ST_FORCE:     cmd.op = mrsd_pkg::CMD_FORCE;
         mrsd_pkg::ST_FL_RD:     cmd.op = mrsd_pkg::CMD_FL_READ;
         mrsd_pkg::ST_FL_CHK: begin
            if (stat.fl_adv) cmd.op = mrsd_pkg::CMD_FL_STEP;
         end
         mrsd_pkg::ST_FL_WIN: begin
            cmd.op = stat.fl_win_more ? mrsd_pkg::CMD_FL_WIN : mrsd_pkg::CMD_FL_END;
         end
         mrsd_pkg::ST_DONE: begin
            if (stat.out_free) cmd.op = mrsd_pkg::CMD_LOAD_OUT;
         end
         default: cmd.op = mrsd_pkg::CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/mrsd_dpath.sv
// datapath: window registers, bitmap memory, counters and result register
`default_nettype none

module mrsd_dpath #(
   parameter int unsigned BITMAP_DEPTH = 256
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_write_enable,
   input  wire  [mrsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire                               csr_write_data,
   input  wire  [mrsd_pkg::SEQ_W-1:0]        req_seq_num,
   input  wire                               req_is_multicast,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_drop,
   output logic [mrsd_pkg::SEQ_W-1:0]        rsp_window_start,
   output logic [31:0]                       rsp_all_count,
   output logic [31:0]                       rsp_fresh_count,
   input  wire mrsd_pkg::dp_cmd_type         cmd,
   output mrsd_pkg::dp_status_type           stat
);

   localparam int unsigned IDXW = $clog2(BITMAP_DEPTH);
   localparam logic [IDXW-1:0] IDX_MASK = IDXW'(BITMAP_DEPTH - 1);
   localparam logic [mrsd_pkg::SEQ_W-1:0] SPAN = mrsd_pkg::SEQ_W'(BITMAP_DEPTH - 1);

   typedef logic [mrsd_pkg::SEQ_W-1:0] seq_type;

   function automatic logic [IDXW-1:0] bit_idx(input seq_type s);
      return s[IDXW-1:0] & IDX_MASK;
   endfunction

   logic    feature_ff, pack_ff, station_ff;
   seq_type seq_ff, rs_ff, re_ff, wl_ff;
   logic [31:0] total_ff, fresh_ff;
   logic    drop_ff;
   logic [IDXW-1:0] clr_ff;
   logic    rd_ff;
   logic    mem [0:BITMAP_DEPTH-1];

   logic    rsp_valid_ff, rsp_drop_ff;
   seq_type rsp_ws_ff;
   logic [31:0] rsp_all_ff, rsp_fresh_ff;

   seq_type seq_inc, rs_inc, wl_inc;
   logic    in_reorder;
   logic    we, wd;
   logic [IDXW-1:0] wa, ra;

   assign seq_inc = seq_ff + 1'b1;
   assign rs_inc  = rs_ff + 1'b1;
   assign wl_inc  = wl_ff + 1'b1;
   assign in_reorder = mrsd_pkg::seq_geq(seq_ff, rs_ff) && mrsd_pkg::seq_lt(seq_ff, re_ff);

   always_comb begin
      stat.clr_last    = (clr_ff == IDXW'(BITMAP_DEPTH - 1));
      stat.tracked     = feature_ff & pack_ff & station_ff & req_is_multicast;
      stat.dup         = mrsd_pkg::seq_lt(seq_ff, rs_ff) || (in_reorder && rd_ff);
      stat.br_a        = in_reorder;
      stat.br_b        = mrsd_pkg::seq_geq(seq_ff, re_ff) && mrsd_pkg::seq_lt(seq_ff, wl_ff);
      stat.br_c        = mrsd_pkg::seq_geq(seq_ff, wl_ff);
      stat.force_b     = mrsd_pkg::seq_geq(seq_inc, wl_ff);
      stat.force_c     = mrsd_pkg::seq_geq(re_ff, wl_ff);
      stat.fl_adv      = mrsd_pkg::seq_lt(rs_ff, re_ff) && rd_ff;
      stat.fl_win_more = (wl_ff != seq_type'(rs_ff + SPAN));
      stat.out_free    = ~rsp_valid_ff | ~rsp_stall;
   end

   // memory port selection
   always_comb begin
      we = 1'b0;
      wd = 1'b0;
      wa = bit_idx(seq_ff);
      ra = bit_idx(rs_ff);
      case (cmd.op)
         mrsd_pkg::CMD_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
         end
         mrsd_pkg::CMD_ACCEPT: ra = bit_idx(req_seq_num);
         mrsd_pkg::CMD_JUDGE: begin
            we = ~stat.dup & (stat.br_a | stat.br_b);
            wd = 1'b1;
         end
         mrsd_pkg::CMD_SLIDE_STEP: begin
            we = 1'b1;
            wa = bit_idx(rs_ff);
         end
         mrsd_pkg::CMD_SLIDE_MARK: begin
            we = 1'b1;
            wd = 1'b1;
         end
         mrsd_pkg::CMD_FORCE, mrsd_pkg::CMD_FL_WIN: begin
            we = 1'b1;
            wa = bit_idx(wl_inc);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feature_ff   <= 1'b0;
         pack_ff      <= 1'b0;
         station_ff   <= 1'b0;
         rs_ff        <= '0;
         re_ff        <= seq_type'(1);
         wl_ff        <= SPAN;
         total_ff     <= '0;
         fresh_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               mrsd_pkg::REG_FEATURE_SWITCH: feature_ff <= csr_write_data;
               mrsd_pkg::REG_PACK_ENABLE:    pack_ff    <= csr_write_data;
               mrsd_pkg::REG_STATION_MODE:   station_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.op == mrsd_pkg::CMD_LOAD_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            mrsd_pkg::CMD_CLEAR: clr_ff <= clr_ff + 1'b1;
            mrsd_pkg::CMD_ACCEPT: begin
               if (stat.tracked) total_ff <= total_ff + 1'b1;
            end
            mrsd_pkg::CMD_JUDGE: begin
               if (!stat.dup) begin
                  fresh_ff <= fresh_ff + 1'b1;
                  if (!stat.br_a && stat.br_b) re_ff <= seq_inc;
               end
            end
            mrsd_pkg::CMD_SLIDE_STEP: begin
               wl_ff <= wl_inc;
               rs_ff <= seq_type'(wl_inc - SPAN);
            end
            mrsd_pkg::CMD_SLIDE_MARK: re_ff <= seq_inc;
            mrsd_pkg::CMD_FORCE: begin
               rs_ff <= rs_inc;
               if (mrsd_pkg::seq_geq(rs_inc, re_ff)) re_ff <= seq_type'(rs_inc + 1'b1);
               wl_ff <= wl_inc;
            end
            mrsd_pkg::CMD_FL_STEP: rs_ff <= rs_inc;
            mrsd_pkg::CMD_FL_WIN:  wl_ff <= wl_inc;
            mrsd_pkg::CMD_FL_END: begin
               if (mrsd_pkg::seq_geq(rs_ff, re_ff)) re_ff <= rs_inc;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         mrsd_pkg::CMD_ACCEPT: begin
            seq_ff  <= req_seq_num;
            drop_ff <= 1'b0;
         end
         mrsd_pkg::CMD_JUDGE: drop_ff <= stat.dup;
         mrsd_pkg::CMD_LOAD_OUT: begin
            rsp_drop_ff  <= drop_ff;
            rsp_ws_ff    <= rs_ff;
            rsp_all_ff   <= total_ff;
            rsp_fresh_ff <= fresh_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drop         = rsp_drop_ff;
   assign rsp_window_start = rsp_ws_ff;
   assign rsp_all_count    = rsp_all_ff;
   assign rsp_fresh_count  = rsp_fresh_ff;

endmodule

`default_nettype wire

### rtl/core/mcast_rx_seq_window_dedup.sv
// result path: an untracked beat goes straight to the result load; a tracked beat is judged
//   first, and a kept beat may then slide the window slot by slot, force a window move,
//   flush reorder slots and clear slots at the new window end before its result loads
// flow: one beat at a time, the next is taken the cycle after the result loads;
//   the bitmap walk is the longest part of a beat, and a stalled result holds the next one off
// reset: synchronous, active high; a clearing pass over every bitmap entry runs with req_stall high
`default_nettype none

module mcast_rx_seq_window_dedup #(
   parameter int unsigned BITMAP_DEPTH = 256
) (
   input  wire                               clock,
   input  wire                               reset,
   // configuration writes
   input  wire                               csr_write_enable,
   input  wire  [mrsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire                               csr_write_data,
   // request beat
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [mrsd_pkg::SEQ_W-1:0]        req_seq_num,
   input  wire                               req_is_multicast,
   // response beat
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_drop,
   output logic [mrsd_pkg::SEQ_W-1:0]        rsp_window_start,
   output logic [31:0]                       rsp_all_count,
   output logic [31:0]                       rsp_fresh_count
);

   // command and status between sequencer and datapath
   mrsd_pkg::dp_cmd_type    cmd;
   mrsd_pkg::dp_status_type stat;

   mrsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // window registers, bitmap and response register live here
   mrsd_dpath #(
      .BITMAP_DEPTH (BITMAP_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_seq_num      (req_seq_num),
      .req_is_multicast (req_is_multicast),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drop         (rsp_drop),
      .rsp_window_start (rsp_window_start),
      .rsp_all_count    (rsp_all_count),
      .rsp_fresh_count  (rsp_fresh_count),
      .cmd              (cmd),
      .stat             (stat)
   );

   // an accepted beat keeps the input stalled until its result is queued
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepted beat");

   // the clearing pass blocks input right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("input open during bitmap clear");

   // a result load never overwrites a pending response beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mrsd_pkg::CMD_LOAD_OUT) |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
